### rtl/mbw_pkg.sv
package mbw_pkg;

   localparam int STORE_BYTES_DEF = 4096;
   localparam int CFG_LEN_RESET   = 4096;
   localparam int CFG_W           = 13;
   localparam int ADDR_OUT_W      = 12;
   localparam int VALUE_W         = 32;
   localparam int WIDTH1_W        = 6;
   localparam int WIDTH23_W       = 5;
   localparam int BITS_W          = 7;
   localparam int FIELD_MAX_W     = 32;
   localparam int STAGE_MAX_W     = 31;
   localparam int NUM_STAGES      = 3;

   typedef enum logic [1:0] {
      CMD_FIELD  = 2'd0,
      CMD_ESCAPE = 2'd1,
      CMD_RESET  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_COMMIT,
      ST_LOAD,
      ST_FILL,
      ST_EMPTY
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic prep_step;
      logic commit;
      logic load;
      logic chunk;
      logic emit_empty;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic prep_last;
      logic empty;
      logic visit_end;
      logic cmd_done;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/msb_first_bit_writer_escape_top.sv
// MSB-first bit writer over a circular byte store. Each accepted word is a
// command: write a field of 0..32 bits (cmd 0), write an escaped value in up
// to three saturating stages (cmd 1), or reset write index, bit position and
// running bit count (cmd 2); cmd 3 does nothing. Every byte the command
// touches comes out as one response word with its address and merged
// contents (bits outside the written span are kept); back-to-back touches of
// the same byte merge into one word. A command that touches no byte gives a
// single word with rsp_byte_valid low. All words of a command carry the
// final total and bit position; rsp_cmd_bits carries the bits written by the
// command on the final word and is 0 on the others; rsp_last marks the final
// one. A command that writes bits evaluates its stages in turn, commits
// its counts, then visits each byte it touches: a registered read of the
// store followed by its chunks (one per byte per stage). A command that
// writes no bits, and a reset or no-op command, gives its single word from
// the empty state. A new word is accepted only when the previous command
// has handed its last word to the output register, which holds while
// rsp_stall is high. The store needs no clearing pass after
// reset: writes always fill a prefix of the store, and a high-water mark
// makes bytes beyond it read as zero. csr_wr_data sets the ring length (0
// acts as 1, values above STORE_BYTES as STORE_BYTES); write it only while
// no command is in flight.
module msb_first_bit_writer_escape_top #(
   parameter int STORE_BYTES = mbw_pkg::STORE_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [mbw_pkg::CFG_W-1:0]        csr_wr_data,
   // command channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [mbw_pkg::VALUE_W-1:0]      req_value,
   input  logic [mbw_pkg::WIDTH1_W-1:0]     req_width1,
   input  logic [mbw_pkg::WIDTH23_W-1:0]    req_width2,
   input  logic [mbw_pkg::WIDTH23_W-1:0]    req_width3,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_byte_valid,
   output logic [mbw_pkg::ADDR_OUT_W-1:0]   rsp_byte_addr,
   output logic [7:0]                       rsp_byte_data,
   output logic [mbw_pkg::BITS_W-1:0]       rsp_cmd_bits,
   output logic [31:0]                      rsp_total_bits,
   output logic [2:0]                       rsp_bit_pos,
   output logic                             rsp_last
);

   // command and status between sequencer and datapath
   mbw_pkg::ctl_cmd_type   ctl;
   mbw_pkg::dp_status_type status;

   // sequencer: accept, evaluate stages, commit counts, visit bytes
   mbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .ctl       (ctl)
   );

   // datapath: positions, stage registers, byte merge, store, output register
   mbw_datapath #(
      .STORE_BYTES (STORE_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_width1     (req_width1),
      .req_width2     (req_width2),
      .req_width3     (req_width3),
      .rsp_stall      (rsp_stall),
      .ctl            (ctl),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_byte_addr  (rsp_byte_addr),
      .rsp_byte_data  (rsp_byte_data),
      .rsp_cmd_bits   (rsp_cmd_bits),
      .rsp_total_bits (rsp_total_bits),
      .rsp_bit_pos    (rsp_bit_pos),
      .rsp_last       (rsp_last)
   );

endmodule

### rtl/mbw_datapath.sv
module mbw_datapath #(
   parameter int STORE_BYTES = mbw_pkg::STORE_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [mbw_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic [1:0]                       req_cmd,
   input  logic [mbw_pkg::VALUE_W-1:0]      req_value,
   input  logic [mbw_pkg::WIDTH1_W-1:0]     req_width1,
   input  logic [mbw_pkg::WIDTH23_W-1:0]    req_width2,
   input  logic [mbw_pkg::WIDTH23_W-1:0]    req_width3,
   input  logic                             rsp_stall,
   input  mbw_pkg::ctl_cmd_type             ctl,
   output mbw_pkg::dp_status_type           status,
   output logic                             rsp_valid,
   output logic                             rsp_byte_valid,
   output logic [mbw_pkg::ADDR_OUT_W-1:0]   rsp_byte_addr,
   output logic [7:0]                       rsp_byte_data,
   output logic [mbw_pkg::BITS_W-1:0]       rsp_cmd_bits,
   output logic [31:0]                      rsp_total_bits,
   output logic [2:0]                       rsp_bit_pos,
   output logic                             rsp_last
);

   localparam int IDX_W     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int LEN_W     = $clog2(STORE_BYTES + 1);
   localparam int LEN_RESET = (mbw_pkg::CFG_LEN_RESET > STORE_BYTES) ?
                              STORE_BYTES : mbw_pkg::CFG_LEN_RESET;
   localparam int NS        = mbw_pkg::NUM_STAGES;

   // position state
   logic [LEN_W-1:0]  len_ff, len_in, len_cfg;
   logic [LEN_W-1:0]  hw_ff, hw_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_next;
   logic [2:0]        pos_ff, pos_in;
   logic [31:0]       total_ff, total_in;

   // command working registers
   mbw_pkg::cmd_type  cmd_ff, cmd_in;
   logic [31:0]       rem_ff, rem_in;
   logic [5:0]        wid_ff [NS];
   logic [5:0]        wid_in [NS];
   logic              alive_ff, alive_in;
   logic [1:0]        prep_cnt_ff, prep_cnt_in;
   logic [31:0]       seg_val_ff [NS];
   logic [31:0]       seg_val_in [NS];
   logic [5:0]        seg_len_ff [NS];
   logic [5:0]        seg_len_in [NS];
   logic [6:0]        bits_ff, bits_in;
   logic [1:0]        sel_ff, sel_in;
   logic [5:0]        nrem_ff, nrem_in;
   logic [2:0]        wpos_ff, wpos_in;
   logic [7:0]        work_ff, work_in;
   logic              fresh_ff, fresh_in;

   // byte store
   logic [7:0]        store_mem [STORE_BYTES];
   logic [7:0]        mem_q_ff;
   logic              hit_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_byte_valid_ff, rsp_byte_valid_in;
   logic [mbw_pkg::ADDR_OUT_W-1:0] rsp_byte_addr_ff, rsp_byte_addr_in;
   logic [7:0]        rsp_byte_data_ff, rsp_byte_data_in;
   logic [6:0]        rsp_bits_ff, rsp_bits_in;
   logic [31:0]       rsp_total_ff, rsp_total_in;
   logic [2:0]        rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   // combinational temporaries
   logic [5:0]        prep_w;
   logic [31:0]       prep_max, prep_v;
   logic [3:0]        room, take;
   logic [2:0]        sh;
   logic [7:0]        mask, chunk8, base, new_byte;
   logic [31:0]       seg_shift, addr_wide, idx_inc;
   logic              full, nxt_found, cmd_done, wrap, same_next, visit_end, out_free;
   logic [5:0]        nrem_left;
   logic [1:0]        nxt_sel, first_sel;
   logic              mem_we;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (csr_wr_data == '0) begin
         len_cfg = LEN_W'(1);
      end else if (32'(csr_wr_data) > 32'(STORE_BYTES)) begin
         len_cfg = LEN_W'(STORE_BYTES);
      end else begin
         len_cfg = LEN_W'(csr_wr_data);
      end
   end

   // stage evaluation, one stage per step: escapes saturate, fields take the value
   always_comb begin
      prep_w   = wid_ff[prep_cnt_ff];
      prep_max = 32'((33'(1) << prep_w) - 33'(1));
      if (cmd_ff == mbw_pkg::CMD_FIELD) begin
         prep_v = rem_ff;
      end else begin
         prep_v = (rem_ff < prep_max) ? rem_ff : prep_max;
      end
   end

   // one chunk: bits that fit into the current byte
   always_comb begin
      room      = {1'b0, wpos_ff} + 4'd1;
      take      = (6'(room) < nrem_ff) ? room : nrem_ff[3:0];
      sh        = 3'(room - take);
      mask      = 8'((9'(1) << take) - 9'(1));
      seg_shift = seg_val_ff[sel_ff] >> (nrem_ff - 6'(take));
      chunk8    = seg_shift[7:0] & mask;
      if (fresh_ff) begin
         base = hit_ff ? mem_q_ff : 8'd0;
      end else begin
         base = work_ff;
      end
      new_byte  = (base & ~(mask << sh)) | (chunk8 << sh);
      full      = (take == room);
      nrem_left = nrem_ff - 6'(take);
      nxt_found = 1'b0;
      nxt_sel   = sel_ff;
      for (int i = NS - 1; i >= 0; i--) begin
         if (2'(i) > sel_ff && seg_len_ff[i] != '0) begin
            nxt_found = 1'b1;
            nxt_sel   = 2'(i);
         end
      end
      first_sel = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (seg_len_ff[i] != '0) begin
            first_sel = 2'(i);
         end
      end
      cmd_done  = (nrem_left == '0) && !nxt_found;
      idx_inc   = 32'(idx_ff) + 32'd1;
      wrap      = idx_inc >= 32'(len_ff);
      idx_next  = wrap ? '0 : IDX_W'(idx_inc);
      same_next = (idx_next == idx_ff);
      visit_end = cmd_done || (full && !same_next);
      addr_wide = 32'(idx_ff);
   end

   assign mem_we = ctl.chunk && visit_end;

   always_comb begin
      len_in      = len_ff;
      hw_in       = hw_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;
      cmd_in      = cmd_ff;
      rem_in      = rem_ff;
      wid_in      = wid_ff;
      alive_in    = alive_ff;
      prep_cnt_in = prep_cnt_ff;
      seg_val_in  = seg_val_ff;
      seg_len_in  = seg_len_ff;
      bits_in     = bits_ff;
      sel_in      = sel_ff;
      nrem_in     = nrem_ff;
      wpos_in     = wpos_ff;
      work_in     = work_ff;
      fresh_in    = fresh_ff;

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_byte_valid_in = rsp_byte_valid_ff;
      rsp_byte_addr_in  = rsp_byte_addr_ff;
      rsp_byte_data_in  = rsp_byte_data_ff;
      rsp_bits_in       = rsp_bits_ff;
      rsp_total_in      = rsp_total_ff;
      rsp_pos_in        = rsp_pos_ff;
      rsp_last_in       = rsp_last_ff;

      if (csr_wr_en) begin
         len_in = len_cfg;
      end

      if (ctl.accept) begin
         cmd_in      = mbw_pkg::cmd_type'(req_cmd);
         rem_in      = req_value;
         alive_in    = 1'b1;
         prep_cnt_in = '0;
         bits_in     = '0;
         if (req_cmd == mbw_pkg::CMD_FIELD) begin
            wid_in[0] = (req_width1 > 6'(mbw_pkg::FIELD_MAX_W)) ?
                        6'(mbw_pkg::FIELD_MAX_W) : req_width1;
         end else begin
            wid_in[0] = (req_width1 > 6'(mbw_pkg::STAGE_MAX_W)) ?
                        6'(mbw_pkg::STAGE_MAX_W) : req_width1;
         end
         wid_in[1] = 6'(req_width2);
         wid_in[2] = 6'(req_width3);
         if (req_cmd == mbw_pkg::CMD_RESET) begin
            idx_in   = '0;
            pos_in   = 3'd7;
            total_in = '0;
         end
      end

      if (ctl.prep_step) begin
         prep_cnt_in = prep_cnt_ff + 2'd1;
         if (alive_ff) begin
            seg_val_in[prep_cnt_ff] = prep_v;
            seg_len_in[prep_cnt_ff] = prep_w;
            bits_in  = bits_ff + 7'(prep_w);
            alive_in = (cmd_ff != mbw_pkg::CMD_FIELD) && (prep_v == prep_max);
            rem_in   = rem_ff - prep_v;
         end else begin
            seg_len_in[prep_cnt_ff] = '0;
         end
      end

      if (ctl.commit) begin
         total_in = total_ff + 32'(bits_ff);
         pos_in   = pos_ff - bits_ff[2:0];
         wpos_in  = pos_ff;
         sel_in   = first_sel;
         nrem_in  = seg_len_ff[first_sel];
      end

      if (ctl.load) begin
         fresh_in = 1'b1;
      end

      if (ctl.chunk) begin
         work_in  = new_byte;
         fresh_in = 1'b0;
         wpos_in  = 3'(wpos_ff - 3'(take));
         if (full) begin
            idx_in = idx_next;
         end
         if (nrem_left == '0 && nxt_found) begin
            sel_in  = nxt_sel;
            nrem_in = seg_len_ff[nxt_sel];
         end else begin
            nrem_in = nrem_left;
         end
         if (visit_end) begin
            if (idx_inc > 32'(hw_ff)) begin
               hw_in = LEN_W'(idx_inc);
            end
            rsp_valid_in      = 1'b1;
            rsp_byte_valid_in = 1'b1;
            rsp_byte_addr_in  = addr_wide[mbw_pkg::ADDR_OUT_W-1:0];
            rsp_byte_data_in  = new_byte;
            rsp_bits_in       = cmd_done ? bits_ff : 7'd0;
            rsp_total_in      = total_ff;
            rsp_pos_in        = pos_ff;
            rsp_last_in       = cmd_done;
         end
      end

      if (ctl.emit_empty) begin
         rsp_valid_in      = 1'b1;
         rsp_byte_valid_in = 1'b0;
         rsp_byte_addr_in  = addr_wide[mbw_pkg::ADDR_OUT_W-1:0];
         rsp_byte_data_in  = 8'd0;
         rsp_bits_in       = bits_ff;
         rsp_total_in      = total_ff;
         rsp_pos_in        = pos_ff;
         rsp_last_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(LEN_RESET);
         hw_ff        <= '0;
         idx_ff       <= '0;
         pos_ff       <= 3'd7;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         hw_ff        <= hw_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      rem_ff            <= rem_in;
      wid_ff            <= wid_in;
      alive_ff          <= alive_in;
      prep_cnt_ff       <= prep_cnt_in;
      seg_val_ff        <= seg_val_in;
      seg_len_ff        <= seg_len_in;
      bits_ff           <= bits_in;
      sel_ff            <= sel_in;
      nrem_ff           <= nrem_in;
      wpos_ff           <= wpos_in;
      work_ff           <= work_in;
      fresh_ff          <= fresh_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_byte_addr_ff  <= rsp_byte_addr_in;
      rsp_byte_data_ff  <= rsp_byte_data_in;
      rsp_bits_ff       <= rsp_bits_in;
      rsp_total_ff      <= rsp_total_in;
      rsp_pos_ff        <= rsp_pos_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // bytes at or above the high-water mark were never written: read as zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[idx_ff] <= new_byte;
      end
      if (ctl.load) begin
         mem_q_ff <= store_mem[idx_ff];
         hit_ff   <= 32'(idx_ff) < 32'(hw_ff);
      end
   end

   always_comb begin
      status.prep_last = (prep_cnt_ff == 2'(NS - 1));
      status.empty     = (bits_ff == '0);
      status.visit_end = visit_end;
      status.cmd_done  = cmd_done;
      status.out_free  = out_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_byte_addr  = rsp_byte_addr_ff;
   assign rsp_byte_data  = rsp_byte_data_ff;
   assign rsp_cmd_bits   = rsp_bits_ff;
   assign rsp_total_bits = rsp_total_ff;
   assign rsp_bit_pos    = rsp_pos_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_hw_covers_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (32'(hw_ff) > 32'($past(idx_ff))))
      else $error("high-water mark below a written byte");

   a_chunk_has_bits: assert property (@(posedge clock) disable iff (reset)
      ctl.chunk |-> (nrem_ff != '0))
      else $error("chunk issued with no bits left");

   a_mid_word_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_bits_ff == '0 && rsp_byte_valid_ff))
      else $error("non-final word carries bit count or no byte");
`endif

endmodule

### rtl/mbw_ctrl.sv
module mbw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_cmd,
   output logic                    req_stall,
   input  mbw_pkg::dp_status_type  status,
   output mbw_pkg::ctl_cmd_type    ctl
);

   mbw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mbw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.accept = 1'b1;
               if (req_cmd == mbw_pkg::CMD_FIELD || req_cmd == mbw_pkg::CMD_ESCAPE) begin
                  state_in = mbw_pkg::ST_PREP;
               end else begin
                  state_in = mbw_pkg::ST_EMPTY;
               end
            end
         end
         mbw_pkg::ST_PREP: begin
            ctl.prep_step = 1'b1;
            if (status.prep_last) begin
               state_in = mbw_pkg::ST_COMMIT;
            end
         end
         mbw_pkg::ST_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = status.empty ? mbw_pkg::ST_EMPTY : mbw_pkg::ST_LOAD;
         end
         mbw_pkg::ST_LOAD: begin
            ctl.load = 1'b1;
            state_in = mbw_pkg::ST_FILL;
         end
         mbw_pkg::ST_FILL: begin
            // hold a byte-ending chunk until the output register can take it
            if (!status.visit_end || status.out_free) begin
               ctl.chunk = 1'b1;
               if (status.cmd_done) begin
                  state_in = mbw_pkg::ST_IDLE;
               end else if (status.visit_end) begin
                  state_in = mbw_pkg::ST_LOAD;
               end
            end
         end
         mbw_pkg::ST_EMPTY: begin
            if (status.out_free) begin
               ctl.emit_empty = 1'b1;
               state_in       = mbw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbw_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbw_pkg::ST_IDLE && req_valid) |=> (state_ff != mbw_pkg::ST_IDLE))
      else $error("accepted word did not start a command");

   a_fill_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbw_pkg::ST_FILL && status.visit_end && !status.out_free)
      |=> (state_ff == mbw_pkg::ST_FILL))
      else $error("byte dropped while output register busy");
`endif

endmodule

### tb/sv/tb_top.sv
module tb_top;
   import mbw_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RING_MAX    = STORE_BYTES_DEF;

   // one command word as the driver presents it
   typedef struct {
      cmd_type     cmd;
      logic [31:0] value;
      logic [5:0]  width1;
      logic [4:0]  width2;
      logic [4:0]  width3;
      bit          drain_first;   // hold back until every byte update is in
   } cmd_word_type;

   // one response word as the block should return it
   typedef struct {
      logic        byte_valid;
      logic [11:0] byte_addr;
      logic [7:0]  byte_data;
      logic [6:0]  cmd_bits;
      logic [31:0] total_bits;
      logic [2:0]  bit_pos;
      logic        last;
   } byte_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]     csr_wr_data = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_cmd     = '0;
   logic [VALUE_W-1:0]   req_value   = '0;
   logic [WIDTH1_W-1:0]  req_width1  = '0;
   logic [WIDTH23_W-1:0] req_width2  = '0;
   logic [WIDTH23_W-1:0] req_width3  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic                 rsp_byte_valid;
   logic [ADDR_OUT_W-1:0] rsp_byte_addr;
   logic [7:0]           rsp_byte_data;
   logic [BITS_W-1:0]    rsp_cmd_bits;
   logic [31:0]          rsp_total_bits;
   logic [2:0]           rsp_bit_pos;
   logic                 rsp_last;

   msb_first_bit_writer_escape_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_width1     (req_width1),
      .req_width2     (req_width2),
      .req_width3     (req_width3),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_byte_addr  (rsp_byte_addr),
      .rsp_byte_data  (rsp_byte_data),
      .rsp_cmd_bits   (rsp_cmd_bits),
      .rsp_total_bits (rsp_total_bits),
      .rsp_bit_pos    (rsp_bit_pos),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the writer: byte store image, write index, bit position,
   // running bit count and the ring length register.
   // ---------------------------------------------------------------------
   logic [7:0]  store_img [0:RING_MAX-1];
   logic [11:0] wr_idx;
   int          bpos;
   logic [31:0] btotal;
   logic [12:0] ring_cfg;

   // bytes touched by the command being packed, merged when consecutive
   logic [11:0] touched_addr [$];
   logic [7:0]  touched_data [$];

   cmd_word_type  cmd_fifo [$];        // words waiting for the driver
   byte_word_type byte_updates [$];    // expected response words, oldest first

   bit quiet;                       // no random gaps and no random stalls while set
   int errors;
   int cmds_sent;
   int bytes_seen;
   int empty_seen;
   int ring_writes;
   int cycle_count;

   function automatic int ring_len();
      int len;
      len = int'(ring_cfg);
      if (len == 0) len = 1;
      if (len > RING_MAX) len = RING_MAX;
      return len;
   endfunction

   // Gap length: mostly none or short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 9);
      return $urandom_range(12, 30);
   endfunction

   // Pack n bits of val MSB first at the current position, merging into
   // the existing byte contents.
   task automatic put_bits(input logic [31:0] val, input int n);
      int          room;
      int          k;
      int          sh;
      int          nxt;
      logic [7:0]  lowm;
      logic [7:0]  chunk;
      logic [7:0]  cur;
      logic [11:0] at;
      btotal += 32'(n);
      while (n > 0) begin
         room  = bpos + 1;
         k     = (room < n) ? room : n;
         sh    = room - k;
         lowm  = 8'((32'd1 << k) - 32'd1);
         chunk = 8'((val >> (n - k)) & ((32'd1 << k) - 32'd1));
         at    = wr_idx;
         cur   = (store_img[at] & ~(lowm << sh)) | (chunk << sh);
         store_img[at] = cur;
         if (touched_addr.size() != 0 && touched_addr[$] == at) begin
            touched_data[$] = cur;
         end else begin
            touched_addr.push_back(at);
            touched_data.push_back(cur);
         end
         bpos = bpos - k;
         n    = n - k;
         if (bpos < 0) begin
            bpos = bpos + 8;
            // a shrunk ring still writes at the old index, then wraps
            nxt = int'(at) + 1;
            if (nxt >= ring_len()) nxt = 0;
            wr_idx = 12'(nxt);
         end
      end
   endtask

   // Up to three saturating stages; stop after the first one that does not
   // hit its all-ones value. A zero-width stage always counts as saturated.
   task automatic put_escape(input logic [31:0] value, input int w1, input int w2,
                             input int w3, output int bits);
      int          sw [3];
      logic [31:0] maxv;
      logic [31:0] v;
      logic [31:0] rest;
      bits  = 0;
      sw[0] = (w1 > STAGE_MAX_W) ? STAGE_MAX_W : w1;
      sw[1] = w2;
      sw[2] = w3;
      rest  = value;
      for (int s = 0; s < NUM_STAGES; s++) begin
         maxv = (32'd1 << sw[s]) - 32'd1;
         v    = (rest < maxv) ? rest : maxv;
         put_bits(v, sw[s]);
         bits += sw[s];
         if (v != maxv) break;
         rest -= v;
      end
   endtask

   // Apply one accepted command to the shadow and queue its response words.
   task automatic pack_command(input cmd_word_type w);
      int            bits;
      int            n;
      byte_word_type r;
      touched_addr.delete();
      touched_data.delete();
      bits = 0;
      case (w.cmd)
         CMD_FIELD: begin
            n = (int'(w.width1) > FIELD_MAX_W) ? FIELD_MAX_W : int'(w.width1);
            put_bits(w.value, n);
            bits = n;
         end
         CMD_ESCAPE: begin
            put_escape(w.value, int'(w.width1), int'(w.width2), int'(w.width3), bits);
         end
         CMD_RESET: begin
            // positions and count only; the store keeps its contents
            wr_idx = '0;
            bpos   = 7;
            btotal = '0;
         end
         default: ;
      endcase
      r.total_bits = btotal;
      r.bit_pos    = 3'(bpos);
      if (touched_addr.size() == 0) begin
         r.byte_valid = 1'b0;
         r.byte_addr  = wr_idx;
         r.byte_data  = 8'd0;
         r.cmd_bits   = 7'(bits);
         r.last       = 1'b1;
         byte_updates.push_back(r);
      end else begin
         for (int i = 0; i < touched_addr.size(); i++) begin
            r.byte_valid = 1'b1;
            r.byte_addr  = touched_addr[i];
            r.byte_data  = touched_data[i];
            r.last       = (i == touched_addr.size() - 1);
            r.cmd_bits   = r.last ? 7'(bits) : 7'd0;
            byte_updates.push_back(r);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: present queued words, hold them while stalled, insert gaps.
   // Prediction happens at the edge that accepts the word.
   // ---------------------------------------------------------------------
   cmd_word_type cur_cmd;
   int           gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pack_command(cur_cmd);
            cmds_sent++;
         end
         // hold the payload untouched while the word is stalled
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_fifo.size() != 0 &&
                         !(cmd_fifo[0].drain_first && byte_updates.size() != 0)) begin
               cur_cmd = cmd_fifo.pop_front();
               req_cmd    <= cur_cmd.cmd;
               req_value  <= cur_cmd.value;
               req_width1 <= cur_cmd.width1;
               req_width2 <= cur_cmd.width2;
               req_width3 <= cur_cmd.width3;
               req_valid  <= 1'b1;
               gap_left = quiet ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each accepted response word with the oldest
   // expectation; stall the response side at random.
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   int            stall_left;
   byte_word_type want_w;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (byte_updates.size() == 0) begin
               $error("response word with no command pending: addr 0x%0h data 0x%0h",
                      rsp_byte_addr, rsp_byte_data);
               errors++;
            end else begin
               want_w = byte_updates.pop_front();
               check_field("byte_valid", 32'(want_w.byte_valid), 32'(rsp_byte_valid));
               check_field("byte_addr", 32'(want_w.byte_addr), 32'(rsp_byte_addr));
               check_field("byte_data", 32'(want_w.byte_data), 32'(rsp_byte_data));
               check_field("cmd_bits", 32'(want_w.cmd_bits), 32'(rsp_cmd_bits));
               check_field("total_bits", want_w.total_bits, rsp_total_bits);
               check_field("bit_pos", 32'(want_w.bit_pos), 32'(rsp_bit_pos));
               check_field("last", 32'(want_w.last), 32'(rsp_last));
               if (want_w.byte_valid) bytes_seen++;
               else empty_seen++;
            end
         end
         if (stall_left == 0 && !quiet)
            stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_cmd(input cmd_type c, input logic [31:0] v, input logic [5:0] w1,
                            input logic [4:0] w2, input logic [4:0] w3);
      cmd_word_type w;
      w.cmd         = c;
      w.value       = v;
      w.width1      = w1;
      w.width2      = w2;
      w.width3      = w3;
      w.drain_first = 1'b0;
      cmd_fifo.push_back(w);
   endtask

   // Mostly well-formed fields and escapes, with escape values aimed at the
   // stage boundaries so that later stages get written.
   function automatic cmd_word_type random_cmd();
      cmd_word_type    w;
      int              pick;
      longint unsigned m1;
      longint unsigned m2;
      longint unsigned m3;
      longint unsigned acc;
      pick          = $urandom_range(0, 99);
      w.value       = $urandom;
      w.width1      = 6'($urandom);
      w.width2      = 5'($urandom);
      w.width3      = 5'($urandom);
      w.drain_first = ($urandom_range(0, 39) == 0);
      if (pick < 45) begin
         w.cmd = CMD_FIELD;
         case ($urandom_range(0, 9))
            0:       w.width1 = 6'($urandom_range(33, 63));
            1:       w.width1 = 6'd8;
            default: w.width1 = 6'($urandom_range(0, 32));
         endcase
         if ($urandom_range(0, 3) == 0) w.value = $urandom_range(0, 255);
      end else if (pick < 88) begin
         w.cmd = CMD_ESCAPE;
         if ($urandom_range(0, 4) != 0) begin
            w.width1 = 6'($urandom_range(0, 8));
            w.width2 = 5'($urandom_range(0, 10));
         end
         m1 = (64'd1 << ((w.width1 > STAGE_MAX_W) ? STAGE_MAX_W : w.width1)) - 1;
         m2 = (64'd1 << w.width2) - 1;
         m3 = (64'd1 << w.width3) - 1;
         case ($urandom_range(0, 3))
            0:       acc = $urandom_range(0, 32'(m1));
            1:       acc = m1 + $urandom_range(0, 32'(m2));
            2:       acc = m1 + m2 + $urandom_range(0, 32'(m3));
            default: acc = w.value;
         endcase
         w.value = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(acc);
      end else if (pick < 96) begin
         w.cmd = CMD_RESET;
      end else begin
         w.cmd = CMD_NOP;
      end
      return w;
   endfunction

   // Wait until the driver is empty and every response word is in.
   task automatic wait_idle();
      while (cmd_fifo.size() != 0 || req_valid || byte_updates.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_ring(input logic [12:0] len);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      ring_cfg = len;
      ring_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count, input bit calm, input bit drain_at_start);
      cmd_word_type w;
      quiet = calm;
      for (int i = 0; i < count; i++) begin
         w = random_cmd();
         if (i == 0 && drain_at_start) w.drain_first = 1'b1;
         cmd_fifo.push_back(w);
      end
   endtask

   initial begin
      for (int i = 0; i < RING_MAX; i++) store_img[i] = 8'd0;
      wr_idx      = '0;
      bpos        = 7;
      btotal      = '0;
      ring_cfg    = 13'(CFG_LEN_RESET);
      quiet       = 1'b0;
      errors      = 0;
      cmds_sent   = 0;
      bytes_seen  = 0;
      empty_seen  = 0;
      ring_writes = 0;
      cycle_count = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of the widths, every command, each corner
      queue_cmd(CMD_FIELD,  32'h0000_0055, 6'd0,  5'd0,  5'd0);   // empty write
      queue_cmd(CMD_FIELD,  32'h0000_00A5, 6'd8,  5'd0,  5'd0);   // aligned byte
      queue_cmd(CMD_FIELD,  32'h0000_0005, 6'd3,  5'd0,  5'd0);
      queue_cmd(CMD_FIELD,  32'hFFFF_FFFF, 6'd32, 5'd0,  5'd0);
      queue_cmd(CMD_FIELD,  32'h0000_0000, 6'd32, 5'd0,  5'd0);
      queue_cmd(CMD_FIELD,  32'h1234_5678, 6'd40, 5'd0,  5'd0);   // wide field
      queue_cmd(CMD_FIELD,  32'h0000_0001, 6'd1,  5'd0,  5'd0);
      queue_cmd(CMD_ESCAPE, 32'h0000_0000, 6'd0,  5'd0,  5'd0);   // all stages empty
      queue_cmd(CMD_ESCAPE, 32'h0000_0000, 6'd4,  5'd4,  5'd4);
      queue_cmd(CMD_ESCAPE, 32'h0000_000F, 6'd4,  5'd3,  5'd2);   // two stages
      queue_cmd(CMD_ESCAPE, 32'h0000_001B, 6'd4,  5'd3,  5'd5);   // three stages
      queue_cmd(CMD_ESCAPE, 32'hFFFF_FFFF, 6'd31, 5'd31, 5'd31);  // 93 bits
      queue_cmd(CMD_ESCAPE, 32'h7FFF_FFFF, 6'd40, 5'd0,  5'd7);   // wide first, empty 2nd
      queue_cmd(CMD_ESCAPE, 32'h0000_0003, 6'd0,  5'd5,  5'd9);   // empty first stage
      queue_cmd(CMD_NOP,    32'h0000_0000, 6'd0,  5'd0,  5'd0);
      queue_cmd(CMD_RESET,  32'h0000_0000, 6'd0,  5'd0,  5'd0);
      queue_cmd(CMD_FIELD,  32'h0000_0000, 6'd5,  5'd0,  5'd0);   // merge over old byte 0
      queue_cmd(CMD_FIELD,  32'hFFFF_FFFF, 6'd63, 5'd31, 5'd31);
      queue_cmd(CMD_ESCAPE, 32'h0000_0000, 6'd63, 5'd31, 5'd31);
      queue_cmd(CMD_RESET,  32'hFFFF_FFFF, 6'd63, 5'd31, 5'd31);  // fields ignored
      queue_cmd(CMD_NOP,    32'hFFFF_FFFF, 6'd63, 5'd31, 5'd31);
      queue_cmd(CMD_FIELD,  32'h0000_0ABC, 6'd12, 5'd0,  5'd0);

      // one-byte ring: once the old index wraps, every touch lands on byte 0 and merges
      set_ring(13'd1);
      run_random(60, 1'b0, 1'b0);
      // zero length acts as one
      set_ring(13'd0);
      run_random(30, 1'b0, 1'b0);
      // short ring, starting with a full drain before the first word
      set_ring(13'd5);
      run_random(80, 1'b0, 1'b1);
      // all ones clamps to the store size
      set_ring(13'h1FFF);
      run_random(80, 1'b0, 1'b0);
      // shrink the ring to half the current write index (at least one)
      wait_idle();
      set_ring((wr_idx > 12'd1) ? 13'(wr_idx / 2) : 13'd1);
      run_random(40, 1'b0, 1'b0);
      // full store, back to back with no random gaps or stalls
      set_ring(13'(RING_MAX));
      run_random(80, 1'b1, 1'b0);
      // random ring length
      set_ring(13'($urandom_range(2, 300)));
      run_random(90, 1'b0, 1'b1);

      wait_idle();
      repeat (40) @(posedge clock);
      if (byte_updates.size() != 0) begin
         $error("%0d response words never arrived", byte_updates.size());
         errors++;
      end

      $display("%0d commands over %0d ring length writes; %0d byte updates, %0d empty words",
               cmds_sent, ring_writes, bytes_seen, empty_seen);
      $display("covered field and escape writes, one-byte and shrunk rings, position reset");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
rtl/mbw_pkg.sv
rtl/mbw_datapath.sv
rtl/mbw_ctrl.sv
rtl/msb_first_bit_writer_escape_top.sv
tb/sv/tb_top.sv
